@@ src/mspt_pkg.sv @@
// Shared constants and types for the markup span to token range mapper.
// Depends on nothing; imported by the top level, markup_span_to_token_range.
`timescale 1ns / 1ps

package mspt_pkg;

   // Tag table capacity and the widths that follow from it.
   localparam int MAX_TAGS       = 64;
   localparam int TAG_ADDR_BITS  = 6;
   localparam int TAG_COUNT_BITS = 7;

   // Token index width and its saturation value.
   localparam int TOKEN_INDEX_BITS = 16;
   localparam logic [TOKEN_INDEX_BITS-1:0] IDX_TOP = '1;

   // One entry of the end-sorted list: end offset above tag number.
   localparam int SORT_BITS = 32 + TAG_ADDR_BITS;

   // Transaction kinds on the request channel.
   localparam logic [1:0] FUNC_LOAD_TAG = 2'd0;
   localparam logic [1:0] FUNC_TOKEN    = 2'd1;
   localparam logic [1:0] FUNC_FINISH   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_SS_RD,
      ST_SS_CMP,
      ST_ES_RD,
      ST_ES_CMP,
      ST_SW_DONE,
      ST_EM_RD,
      ST_EM_WAIT
   } state_type;

endpackage

@@ src/mspt_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing; the read register holds its value while no read is issued.
`timescale 1ns / 1ps

module mspt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/markup_span_to_token_range.sv @@
// Top level of the markup span to token range mapper: sequencer and tag stores.
// Depends on mspt_pkg and mspt_ram.
`timescale 1ns / 1ps

// A run loads up to 64 tags (start and end character offsets), then streams
// tokens (offset and length), then a finish transaction emits one result per
// tag in load order, the final one marked by rsp_tlast. The block takes one
// transaction at a time. Each tag is placed in the end-sorted list by an
// insertion pass over one RAM port that moves every earlier tag whose end
// offset is larger up one place. The first token of a run is only held as
// pending. Every later token settles the pending one: the start and end
// cursors step through RAM one entry per read and compare, recording each
// tag whose first or last token it is. A finish runs one such pass for the
// pending token, if there is one, and a pass that fills the unassigned tags,
// then emits the results, each held until the receiver takes it.
// The compare unit sees one RAM word per step.
module markup_span_to_token_range
   import mspt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // [31:0] start_offset, [63:32] extent
   input  logic [1:0]  req_tuser,  // [1:0] func
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [5:0] tag_number, [21:6] first_token,
                                   // [37:22] last_token, [39:38] zero
   output logic [0:0]  rsp_tuser,  // [0] no_tokens
   output logic        rsp_tlast   // last_result
);

   state_type state_ff, state_in;

   logic [TAG_COUNT_BITS-1:0]   held_ff, held_in;
   logic [TAG_COUNT_BITS-1:0]   sc_ff, sc_in;
   logic [TAG_COUNT_BITS-1:0]   ec_ff, ec_in;
   logic [TAG_COUNT_BITS-1:0]   k_ff, k_in;
   logic [TOKEN_INDEX_BITS-1:0] tok_ff, tok_in;
   logic [TOKEN_INDEX_BITS-1:0] sw_idx_ff, sw_idx_in;
   logic [31:0]                 pend_off_ff, pend_off_in;
   logic [31:0]                 pend_len_ff, pend_len_in;
   logic                        pend_v_ff, pend_v_in;
   logic [31:0]                 nxt_off_ff, nxt_off_in;
   logic [31:0]                 nxt_len_ff, nxt_len_in;
   logic [31:0]                 cur_off_ff, cur_off_in;
   logic [32:0]                 ext_ff, ext_in;
   logic [31:0]                 new_end_ff, new_end_in;
   logic                        fin_ff, fin_in;
   logic                        fill_ff, fill_in;
   logic                        none_ff, none_in;

   logic        req_acc;
   logic [31:0] req_a;
   logic [31:0] req_b;
   logic        load_ok;

   // RAM ports.
   logic                        start_we, start_re;
   logic [TAG_ADDR_BITS-1:0]    start_wa, start_ra;
   logic [31:0]                 start_q;
   logic                        sort_we, sort_re;
   logic [TAG_ADDR_BITS-1:0]    sort_wa, sort_ra;
   logic [SORT_BITS-1:0]        sort_wd, sort_q;
   logic                        first_we, first_re;
   logic [TAG_ADDR_BITS-1:0]    first_wa;
   logic [TOKEN_INDEX_BITS-1:0] first_q;
   logic                        last_we, last_re;
   logic [TAG_ADDR_BITS-1:0]    last_wa;
   logic [TOKEN_INDEX_BITS-1:0] last_q;
   logic [31:0]                 sort_end;
   logic [TAG_ADDR_BITS-1:0]    sort_tag;

   assign req_a    = req_tdata[31:0];
   assign req_b    = req_tdata[63:32];
   assign req_acc  = req_tvalid && req_tready;
   assign sort_end = sort_q[SORT_BITS-1:TAG_ADDR_BITS];
   assign sort_tag = sort_q[TAG_ADDR_BITS-1:0];
   assign load_ok  = !pend_v_ff && (tok_ff == '0) &&
                     (held_ff < TAG_COUNT_BITS'(MAX_TAGS));

   // Tag start offsets in load order.
   mspt_ram #(.WIDTH(32), .DEPTH(MAX_TAGS)) u_start_ram (
      .clock  (clock),
      .wr_en  (start_we),
      .wr_addr(start_wa),
      .wr_data(req_a),
      .rd_en  (start_re),
      .rd_addr(start_ra),
      .rd_data(start_q)
   );

   // End offsets with tag numbers, sorted by end offset.
   mspt_ram #(.WIDTH(SORT_BITS), .DEPTH(MAX_TAGS)) u_sort_ram (
      .clock  (clock),
      .wr_en  (sort_we),
      .wr_addr(sort_wa),
      .wr_data(sort_wd),
      .rd_en  (sort_re),
      .rd_addr(sort_ra),
      .rd_data(sort_q)
   );

   // First token index of each tag.
   mspt_ram #(.WIDTH(TOKEN_INDEX_BITS), .DEPTH(MAX_TAGS)) u_first_ram (
      .clock  (clock),
      .wr_en  (first_we),
      .wr_addr(first_wa),
      .wr_data(sw_idx_ff),
      .rd_en  (first_re),
      .rd_addr(k_ff[TAG_ADDR_BITS-1:0]),
      .rd_data(first_q)
   );

   // Last token index of each tag.
   mspt_ram #(.WIDTH(TOKEN_INDEX_BITS), .DEPTH(MAX_TAGS)) u_last_ram (
      .clock  (clock),
      .wr_en  (last_we),
      .wr_addr(last_wa),
      .wr_data(sw_idx_ff),
      .rd_en  (last_re),
      .rd_addr(k_ff[TAG_ADDR_BITS-1:0]),
      .rd_data(last_q)
   );

   // State and run registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff  <= '0;
         sc_ff    <= '0;
         ec_ff    <= '0;
         tok_ff   <= '0;
         pend_v_ff <= 1'b0;
         pend_off_ff <= '0;
         pend_len_ff <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         sc_ff    <= sc_in;
         ec_ff    <= ec_in;
         tok_ff   <= tok_in;
         pend_v_ff <= pend_v_in;
         pend_off_ff <= pend_off_in;
         pend_len_ff <= pend_len_in;
      end
   end

   // Working registers of the current transaction.
   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      sw_idx_ff  <= sw_idx_in;
      nxt_off_ff <= nxt_off_in;
      nxt_len_ff <= nxt_len_in;
      cur_off_ff <= cur_off_in;
      ext_ff     <= ext_in;
      new_end_ff <= new_end_in;
      fin_ff     <= fin_in;
      fill_ff    <= fill_in;
      none_ff    <= none_in;
   end

   // Sequencer: next state, register updates and RAM controls.
   always_comb begin
      state_in    = state_ff;
      held_in     = held_ff;
      sc_in       = sc_ff;
      ec_in       = ec_ff;
      k_in        = k_ff;
      tok_in      = tok_ff;
      sw_idx_in   = sw_idx_ff;
      pend_off_in = pend_off_ff;
      pend_len_in = pend_len_ff;
      pend_v_in   = pend_v_ff;
      nxt_off_in  = nxt_off_ff;
      nxt_len_in  = nxt_len_ff;
      cur_off_in  = cur_off_ff;
      ext_in      = ext_ff;
      new_end_in  = new_end_ff;
      fin_in      = fin_ff;
      fill_in     = fill_ff;
      none_in     = none_ff;

      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_EM_WAIT);

      start_we = 1'b0;
      start_wa = held_ff[TAG_ADDR_BITS-1:0];
      start_re = 1'b0;
      start_ra = sc_ff[TAG_ADDR_BITS-1:0];
      sort_we  = 1'b0;
      sort_wa  = k_ff[TAG_ADDR_BITS-1:0];
      sort_wd  = {new_end_ff, held_ff[TAG_ADDR_BITS-1:0]};
      sort_re  = 1'b0;
      sort_ra  = TAG_ADDR_BITS'(k_ff - TAG_COUNT_BITS'(1));
      first_we = 1'b0;
      first_wa = sc_ff[TAG_ADDR_BITS-1:0];
      first_re = 1'b0;
      last_we  = 1'b0;
      last_wa  = sort_tag;
      last_re  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_tuser)
                  FUNC_LOAD_TAG: begin
                     if (load_ok) begin
                        start_we   = 1'b1;
                        k_in       = held_ff;
                        new_end_in = req_b;
                        state_in   = ST_INS_RD;
                     end
                  end
                  FUNC_TOKEN: begin
                     if (pend_v_ff) begin
                        nxt_off_in = req_a;
                        nxt_len_in = req_b;
                        sw_idx_in  = tok_ff;
                        cur_off_in = pend_off_ff;
                        ext_in     = {1'b0, req_a};
                        fin_in     = 1'b0;
                        fill_in    = 1'b0;
                        state_in   = ST_SS_RD;
                     end else begin
                        pend_off_in = req_a;
                        pend_len_in = req_b;
                        pend_v_in   = 1'b1;
                     end
                  end
                  FUNC_FINISH: begin
                     fin_in     = 1'b1;
                     none_in    = !pend_v_ff;
                     cur_off_in = pend_off_ff;
                     ext_in     = {1'b0, pend_off_ff} + {1'b0, pend_len_ff};
                     sw_idx_in  = pend_v_ff ? tok_ff : IDX_TOP;
                     fill_in    = !pend_v_ff;
                     state_in   = ST_SS_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Insertion from the top: larger ends move up one place.
         ST_INS_RD: begin
            if (k_ff == '0) begin
               sort_we  = 1'b1;
               held_in  = held_ff + TAG_COUNT_BITS'(1);
               state_in = ST_IDLE;
            end else begin
               sort_re  = 1'b1;
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            sort_we = 1'b1;
            if (sort_end > new_end_ff) begin
               sort_wd  = sort_q;
               k_in     = k_ff - TAG_COUNT_BITS'(1);
               state_in = ST_INS_RD;
            end else begin
               held_in  = held_ff + TAG_COUNT_BITS'(1);
               state_in = ST_IDLE;
            end
         end

         // Start sweep in load order.
         ST_SS_RD: begin
            if (sc_ff < held_ff) begin
               start_re = 1'b1;
               state_in = ST_SS_CMP;
            end else begin
               state_in = ST_ES_RD;
            end
         end
         ST_SS_CMP: begin
            if (fill_ff || (start_q <= cur_off_ff)) begin
               first_we = 1'b1;
               sc_in    = sc_ff + TAG_COUNT_BITS'(1);
               state_in = ST_SS_RD;
            end else begin
               state_in = ST_ES_RD;
            end
         end

         // End sweep in end order.
         ST_ES_RD: begin
            if (ec_ff < held_ff) begin
               sort_re  = 1'b1;
               sort_ra  = ec_ff[TAG_ADDR_BITS-1:0];
               state_in = ST_ES_CMP;
            end else begin
               state_in = ST_SW_DONE;
            end
         end
         ST_ES_CMP: begin
            if (fill_ff || ({1'b0, sort_end} < ext_ff)) begin
               last_we  = 1'b1;
               ec_in    = ec_ff + TAG_COUNT_BITS'(1);
               state_in = ST_ES_RD;
            end else begin
               state_in = ST_SW_DONE;
            end
         end

         // Sweep finished: close the token, start the fill, start emitting, or clear an empty run.
         ST_SW_DONE: begin
            if (!fin_ff) begin
               if (tok_ff != IDX_TOP) begin
                  tok_in = tok_ff + TOKEN_INDEX_BITS'(1);
               end
               pend_off_in = nxt_off_ff;
               pend_len_in = nxt_len_ff;
               state_in    = ST_IDLE;
            end else if (!fill_ff) begin
               fill_in  = 1'b1;
               state_in = ST_SS_RD;
            end else begin
               k_in = '0;
               if (held_ff == '0) begin
                  held_in     = '0;
                  sc_in       = '0;
                  ec_in       = '0;
                  tok_in      = '0;
                  pend_off_in = '0;
                  pend_len_in = '0;
                  pend_v_in   = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  state_in = ST_EM_RD;
               end
            end
         end

         // Result emission in load order.
         ST_EM_RD: begin
            first_re = 1'b1;
            last_re  = 1'b1;
            state_in = ST_EM_WAIT;
         end
         ST_EM_WAIT: begin
            if (rsp_tready) begin
               if (k_ff + TAG_COUNT_BITS'(1) == held_ff) begin
                  held_in     = '0;
                  sc_in       = '0;
                  ec_in       = '0;
                  tok_in      = '0;
                  pend_off_in = '0;
                  pend_len_in = '0;
                  pend_v_in   = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  k_in     = k_ff + TAG_COUNT_BITS'(1);
                  state_in = ST_EM_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result payload: token indices straight from the RAM read registers, tag number from k_ff.
   assign rsp_tdata = {2'b00, last_q, first_q, k_ff[TAG_ADDR_BITS-1:0]};
   assign rsp_tuser = none_ff;
   assign rsp_tlast = (k_ff + TAG_COUNT_BITS'(1) == held_ff);

   // A result never waits while a new transaction is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while a result is pending");

   // The tag count never passes the table capacity.
   assert property (@(posedge clock) disable iff (reset)
      held_ff <= TAG_COUNT_BITS'(MAX_TAGS))
      else $error("tag count beyond capacity");

   // Both sweep cursors stay within the loaded tags.
   assert property (@(posedge clock) disable iff (reset)
      (sc_ff <= held_ff) && (ec_ff <= held_ff))
      else $error("sweep cursor past loaded tags");

   // The final result of a run clears the run.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (held_ff == '0) && !pend_v_ff)
      else $error("run state not cleared after final result");

endmodule
